FILE: rtl/core/sung_pkg.sv
// shared types, constants and register codes of the super ugly number generator
`default_nettype none

package sung_pkg;

  localparam int PRIME_SLOTS      = 6;
  localparam int PRIME_W          = 16;
  localparam int VALUE_W          = 31;
  localparam int PROD_W           = VALUE_W + PRIME_W;
  localparam int POS_W            = 11;
  localparam int COUNT_W          = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;
  localparam int DEF_MAX_POSITION = 1024;
  localparam int DEF_MAX_PRIMES   = 6;

  localparam logic [VALUE_W-1:0] SAT_LIMIT = 31'h7FFF_FFFF;

  localparam logic [COUNT_W-1:0] RST_PRIME_COUNT = 3'd3;
  localparam logic [PRIME_W-1:0] RST_PRIME [PRIME_SLOTS] = '{
    16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIME_COUNT = 3'd0,
    REG_PRIME_0     = 3'd1,
    REG_PRIME_1     = 3'd2,
    REG_PRIME_2     = 3'd3,
    REG_PRIME_3     = 3'd4,
    REG_PRIME_4     = 3'd5,
    REG_PRIME_5     = 3'd6
  } sung_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_MUL,
    ST_CMP,
    ST_WRITE,
    ST_FETCH,
    ST_LOAD,
    ST_ZERO
  } sung_state_e;

  typedef struct packed {
    logic init;
    logic rd_ptr;
    logic mul;
    logic cmp;
    logic write_elem;
    logic rd_final;
    logic load_out;
    logic load_zero;
  } sung_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/sung_dp.sv
// datapath: sequence store, prime pointers, multiplier, minimum search and result register
`default_nettype none

module sung_dp
  import sung_pkg::*;
#(
  parameter int MAX_POSITION = DEF_MAX_POSITION,
  parameter int MAX_PRIMES   = DEF_MAX_PRIMES,
  localparam int AW = (MAX_POSITION > 1) ? $clog2(MAX_POSITION) : 1,
  localparam int JW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sung_cmd_t          cmd_i,
  input  wire logic [JW-1:0]      j_i,
  input  wire logic [AW-1:0]      idx_i,
  input  wire logic [COUNT_W-1:0] cnt_i,
  input  wire logic [PRIME_W-1:0] prime_i [MAX_PRIMES],
  output logic [VALUE_W-1:0]      sequence_value_o,
  output logic                    overflow_o
);

  logic [VALUE_W-1:0] store_q [MAX_POSITION];
  logic [VALUE_W-1:0] rd_q;
  logic [PROD_W-1:0]  prod_q;
  logic [VALUE_W-1:0] best_q, best_d;
  logic [VALUE_W-1:0] psat_q [MAX_PRIMES];
  logic [AW-1:0]      ptr_q [MAX_PRIMES];
  logic [AW-1:0]      ptr_d [MAX_PRIMES];
  logic               ovf_q, ovf_d;
  logic [VALUE_W-1:0] value_q;
  logic               ovf_out_q;

  logic               wr_en, rd_en;
  logic [VALUE_W-1:0] wr_data;
  logic [AW-1:0]      rd_addr;
  logic               prod_big;
  logic [VALUE_W-1:0] sat_val;

  assign wr_en   = cmd_i.init | cmd_i.write_elem;
  assign wr_data = cmd_i.init ? VALUE_W'(1) : best_q;
  assign rd_en   = cmd_i.rd_ptr | cmd_i.rd_final;
  assign rd_addr = cmd_i.rd_final ? idx_i : ptr_q[j_i];

  // sequence store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[idx_i] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= store_q[rd_addr];
    end
  end

  assign prod_big = prod_q > PROD_W'(SAT_LIMIT);
  assign sat_val  = prod_big ? SAT_LIMIT : prod_q[VALUE_W-1:0];

  always_comb begin
    best_d = best_q;
    ovf_d  = ovf_q;
    for (int k = 0; k < MAX_PRIMES; k++) begin
      ptr_d[k] = ptr_q[k];
    end
    if (cmd_i.init) begin
      ovf_d = 1'b0;
      for (int k = 0; k < MAX_PRIMES; k++) begin
        ptr_d[k] = '0;
      end
    end
    if (cmd_i.cmp) begin
      if (j_i == '0 || sat_val < best_q) begin
        best_d = sat_val;
      end
      if (prod_big) begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.write_elem) begin
      for (int k = 0; k < MAX_PRIMES; k++) begin
        if (COUNT_W'(k) < cnt_i && psat_q[k] == best_q) begin
          ptr_d[k] = ptr_q[k] + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
      for (int k = 0; k < MAX_PRIMES; k++) begin
        ptr_q[k] <= '0;
      end
    end else begin
      ovf_q <= ovf_d;
      for (int k = 0; k < MAX_PRIMES; k++) begin
        ptr_q[k] <= ptr_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(rd_q) * PROD_W'(prime_i[j_i]);
    end
    if (cmd_i.cmp) begin
      psat_q[j_i] <= sat_val;
    end
    if (cmd_i.load_out) begin
      value_q   <= rd_q;
      ovf_out_q <= ovf_q;
    end else if (cmd_i.load_zero) begin
      value_q   <= '0;
      ovf_out_q <= 1'b0;
    end
  end

  assign sequence_value_o = value_q;
  assign overflow_o       = ovf_out_q;

endmodule

`default_nettype wire

FILE: rtl/core/sung_ctrl.sv
// controller: request sequencing, element and prime counters, result handshake
`default_nettype none

module sung_ctrl
  import sung_pkg::*;
#(
  parameter int MAX_POSITION = DEF_MAX_POSITION,
  parameter int MAX_PRIMES   = DEF_MAX_PRIMES,
  localparam int AW = (MAX_POSITION > 1) ? $clog2(MAX_POSITION) : 1,
  localparam int JW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1,
  localparam int NW = $clog2(MAX_POSITION + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [POS_W-1:0]   requested_position_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire logic [COUNT_W-1:0] cnt_i,
  output sung_cmd_t               cmd_o,
  output logic [JW-1:0]           j_o,
  output logic [AW-1:0]           idx_o
);

  sung_state_e   state_q, state_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] i_q, i_d;
  logic [JW-1:0] j_q, j_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free, last_prime, last_elem;

  assign out_free   = !out_valid_q || out_ready_i;
  assign last_prime = COUNT_W'(j_q) == cnt_i - COUNT_W'(1);
  assign last_elem  = i_q + NW'(1) == n_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (requested_position_i == '0) ? ST_ZERO : ST_INIT;
        end
      end
      ST_INIT:  state_d = (n_q == NW'(1)) ? ST_FETCH : ST_READ;
      ST_READ:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_CMP;
      ST_CMP:   state_d = last_prime ? ST_WRITE : ST_READ;
      ST_WRITE: state_d = last_elem ? ST_FETCH : ST_READ;
      ST_FETCH: state_d = ST_LOAD;
      ST_LOAD, ST_ZERO: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    n_d = n_q;
    i_d = i_q;
    j_d = j_q;
    unique case (state_q)
      ST_IDLE: begin
        if (32'(requested_position_i) > MAX_POSITION) begin
          n_d = NW'(MAX_POSITION);
        end else begin
          n_d = NW'(requested_position_i);
        end
      end
      ST_INIT: begin
        i_d = NW'(1);
        j_d = '0;
      end
      ST_CMP:   j_d = last_prime ? '0 : j_q + JW'(1);
      ST_WRITE: i_d = i_q + NW'(1);
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    idx_o      = i_q[AW-1:0];
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_INIT: begin
        cmd_o.init = 1'b1;
        idx_o      = '0;
      end
      ST_READ:  cmd_o.rd_ptr     = 1'b1;
      ST_MUL:   cmd_o.mul        = 1'b1;
      ST_CMP:   cmd_o.cmp        = 1'b1;
      ST_WRITE: cmd_o.write_elem = 1'b1;
      ST_FETCH: begin
        cmd_o.rd_final = 1'b1;
        idx_o          = AW'(n_q - NW'(1));
      end
      ST_LOAD:  cmd_o.load_out  = out_free;
      ST_ZERO:  cmd_o.load_zero = out_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out || cmd_o.load_zero) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign j_o         = j_q;

endmodule

`default_nettype wire

FILE: rtl/core/super_ugly_number_generator.sv
// top level: configuration registers, controller and datapath of the super ugly number generator
//
// usage
//   input channel  : in_valid_i / in_ready_o carry requested_position_i (one-based n)
//   output channel : out_valid_o / out_ready_i carry sequence_value_o and overflow_o
//   config port    : cfg_we_i writes cfg_data_i into register cfg_index_i (0 prime count,
//                    1..6 primes); the user must write only while idle, the block does not check
//   one request is taken at a time; it is rebuilt from element 1 in the sequence store
//   each element costs one store read, one multiply and one compare per prime, in turn
//   through the single read port and multiplier, plus one store write; a position of
//   zero answers zero without building the sequence
//   the result waits in an output register; the next request is taken while it waits,
//   and a finished request holds until the receiver takes the earlier result
//   reset restores primes 2,3,5,7,11,13 with three in use; the store needs no clearing
`default_nettype none

module super_ugly_number_generator
  import sung_pkg::*;
#(
  parameter int MAX_POSITION = DEF_MAX_POSITION,
  parameter int MAX_PRIMES   = DEF_MAX_PRIMES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [POS_W-1:0]      requested_position_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [VALUE_W-1:0]         sequence_value_o,
  output logic                       overflow_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = (MAX_POSITION > 1) ? $clog2(MAX_POSITION) : 1;
  localparam int JW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

  logic [COUNT_W-1:0] prime_count_q;
  logic [PRIME_W-1:0] prime_q [PRIME_SLOTS];
  logic [PRIME_W-1:0] prime_use [MAX_PRIMES];
  logic [COUNT_W-1:0] cnt_eff;
  sung_cmd_t          cmd;
  logic [JW-1:0]      j;
  logic [AW-1:0]      idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_count_q <= RST_PRIME_COUNT;
      for (int k = 0; k < PRIME_SLOTS; k++) begin
        prime_q[k] <= RST_PRIME[k];
      end
    end else if (cfg_we_i) begin
      case (sung_reg_e'(cfg_index_i))
        REG_PRIME_COUNT: prime_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_PRIME_0:     prime_q[0]    <= cfg_data_i;
        REG_PRIME_1:     prime_q[1]    <= cfg_data_i;
        REG_PRIME_2:     prime_q[2]    <= cfg_data_i;
        REG_PRIME_3:     prime_q[3]    <= cfg_data_i;
        REG_PRIME_4:     prime_q[4]    <= cfg_data_i;
        REG_PRIME_5:     prime_q[5]    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // prime count held within one and the number of prime slots built
  always_comb begin
    if (prime_count_q == '0) begin
      cnt_eff = COUNT_W'(1);
    end else if (prime_count_q > COUNT_W'(MAX_PRIMES)) begin
      cnt_eff = COUNT_W'(MAX_PRIMES);
    end else begin
      cnt_eff = prime_count_q;
    end
    for (int k = 0; k < MAX_PRIMES; k++) begin
      prime_use[k] = prime_q[k];
    end
  end

  sung_ctrl #(
    .MAX_POSITION (MAX_POSITION),
    .MAX_PRIMES   (MAX_PRIMES)
  ) u_ctrl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .requested_position_i (requested_position_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .cnt_i                (cnt_eff),
    .cmd_o                (cmd),
    .j_o                  (j),
    .idx_o                (idx)
  );

  sung_dp #(
    .MAX_POSITION (MAX_POSITION),
    .MAX_PRIMES   (MAX_PRIMES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .j_i              (j),
    .idx_i            (idx),
    .cnt_i            (cnt_eff),
    .prime_i          (prime_use),
    .sequence_value_o (sequence_value_o),
    .overflow_o       (overflow_o)
  );

endmodule

`default_nettype wire

FILE: sim/super_ugly_number_generator_test.sv
// testbench of the super ugly number generator: directed and random requests checked against a predictor
module super_ugly_number_generator_test;
  import sung_pkg::*;

  localparam int IDLE_LIMIT     = 100000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_REQUESTS = 20;
  localparam int DRAIN_CYCLES   = 50;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               overflow;
  } sung_answer_t;

  class nth_number_scoreboard;
    logic [COUNT_W-1:0] count_reg;
    logic [PRIME_W-1:0] prime_reg [PRIME_SLOTS];
    logic [31:0]        seq_store [DEF_MAX_POSITION];
    logic [9:0]         prime_ptr [PRIME_SLOTS];
    logic               overflow_seen;
    sung_answer_t       awaited [$];
    int                 errors;

    function new();
      count_reg = RST_PRIME_COUNT;
      foreach (prime_reg[k]) prime_reg[k] = RST_PRIME[k];
      foreach (prime_ptr[k]) prime_ptr[k] = '0;
      overflow_seen = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PRIME_COUNT: count_reg = data[COUNT_W-1:0];
        REG_PRIME_0: prime_reg[0] = data;
        REG_PRIME_1: prime_reg[1] = data;
        REG_PRIME_2: prime_reg[2] = data;
        REG_PRIME_3: prime_reg[3] = data;
        REG_PRIME_4: prime_reg[4] = data;
        REG_PRIME_5: prime_reg[5] = data;
        default: ;
      endcase
    endfunction

    function logic [31:0] clamped_product(logic [31:0] elem, logic [PRIME_W-1:0] p);
      logic [63:0] prod;
      prod = 64'(elem) * 64'(p);
      if (prod > 64'(SAT_LIMIT)) begin
        overflow_seen = 1'b1;
        return 32'(SAT_LIMIT);
      end
      return prod[31:0];
    endfunction

    function sung_answer_t nth_number(logic [POS_W-1:0] pos);
      sung_answer_t ans;
      int           n;
      int           used;
      logic [31:0]  best;
      logic [31:0]  prod;
      n = int'(pos);
      used = int'(count_reg);
      if (used < 1) used = 1;
      if (used > DEF_MAX_PRIMES) used = DEF_MAX_PRIMES;
      ans.value = '0;
      ans.overflow = 1'b0;
      if (n == 0) return ans;
      if (n > DEF_MAX_POSITION) n = DEF_MAX_POSITION;
      overflow_seen = 1'b0;
      foreach (prime_ptr[k]) prime_ptr[k] = '0;
      seq_store[0] = 32'd1;
      for (int i = 1; i < n; i++) begin
        best = 32'(SAT_LIMIT);
        for (int j = 0; j < used; j++) begin
          prod = clamped_product(seq_store[prime_ptr[j]], prime_reg[j]);
          if (prod < best) best = prod;
        end
        seq_store[i] = best;
        // every prime that hit the minimum moves on, so duplicates are skipped
        for (int j = 0; j < used; j++) begin
          prod = clamped_product(seq_store[prime_ptr[j]], prime_reg[j]);
          if (prod == best) prime_ptr[j] = prime_ptr[j] + 10'd1;
        end
      end
      ans.value = seq_store[n-1][VALUE_W-1:0];
      ans.overflow = overflow_seen;
      return ans;
    endfunction

    function void note_request(logic [POS_W-1:0] pos);
      awaited.push_back(nth_number(pos));
    endfunction

    function void check_answer(logic [VALUE_W-1:0] value, logic overflow);
      sung_answer_t want;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding: sequence_value %0d overflow %0b",
               value, overflow);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        $error("sequence_value: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, overflow);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                  clk_i                = 1'b0;
  logic                  rst_ni               = 1'b0;
  logic                  in_valid_i           = 1'b0;
  logic                  in_ready_o;
  logic [POS_W-1:0]      requested_position_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i          = 1'b0;
  logic [VALUE_W-1:0]    sequence_value_o;
  logic                  overflow_o;
  logic                  cfg_we_i             = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i          = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i           = '0;

  nth_number_scoreboard board = new();
  bit steady = 1'b0;
  int idle_cycles = 0;

  super_ugly_number_generator #(
    .MAX_POSITION(DEF_MAX_POSITION),
    .MAX_PRIMES  (DEF_MAX_PRIMES)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .requested_position_i(requested_position_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .sequence_value_o    (sequence_value_o),
    .overflow_o          (overflow_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_request(requested_position_i);
      if (out_valid_o && out_ready_i) board.check_answer(sequence_value_o, overflow_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int request_gap();
    int r;
    r = $urandom_range(0, 9);
    if (steady || r < 4) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int sink_stall();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [POS_W-1:0] random_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 88) return POS_W'($urandom_range(1, 64));
    if (r < 97) return POS_W'($urandom_range(65, 400));
    return POS_W'($urandom_range(401, 2047));
  endfunction

  function automatic logic [PRIME_W-1:0] random_prime();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return PRIME_W'(1);
    if (r < 5) return PRIME_W'($urandom_range(2, 65535));
    return PRIME_W'($urandom_range(2, 23));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_count_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CFG_DATA_W'($urandom);
    if (r == 1) return ($urandom_range(0, 1) == 0) ? CFG_DATA_W'(0) : CFG_DATA_W'(7);
    return CFG_DATA_W'($urandom_range(1, DEF_MAX_PRIMES));
  endfunction

  task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    board.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] count_word,
                               logic [PRIME_W-1:0] p0, logic [PRIME_W-1:0] p1,
                               logic [PRIME_W-1:0] p2, logic [PRIME_W-1:0] p3,
                               logic [PRIME_W-1:0] p4, logic [PRIME_W-1:0] p5);
    write_one(REG_PRIME_COUNT, count_word);
    write_one(REG_PRIME_0, p0);
    write_one(REG_PRIME_1, p1);
    write_one(REG_PRIME_2, p2);
    write_one(REG_PRIME_3, p3);
    write_one(REG_PRIME_4, p4);
    write_one(REG_PRIME_5, p5);
    // unmapped index, must leave everything as it was
    write_one(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_request(logic [POS_W-1:0] pos);
    int gap;
    gap = request_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    requested_position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic finish_burst();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.outstanding() != 0);
  endtask

  initial begin
    int len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat (sink_stall()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 6);
      repeat (len) @(posedge clk_i);
    end
  end

  initial begin
    logic [PRIME_W-1:0] pick [PRIME_SLOTS];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset primes, position zero and positions past the store size
    send_request(11'd0);
    send_request(11'd1);
    send_request(11'd2);
    send_request(11'd7);
    send_request(11'd2047);
    finish_burst();

    apply_setting(16'd6, 16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13);
    send_request(11'd1024);
    send_request(11'd15);
    finish_burst();

    // count field saturates to six, largest primes overflow from the third position on
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(11'd2);
    send_request(11'd3);
    send_request(11'd4);
    send_request(11'd60);
    finish_burst();

    // count of zero behaves as one, prime of zero
    apply_setting(16'd0, 16'd0, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13);
    send_request(11'd1);
    send_request(11'd2);
    send_request(11'd9);
    finish_burst();

    // prime of one gives repeated ones
    apply_setting(16'd2, 16'd1, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(11'd6);
    send_request(11'd12);
    finish_burst();

    // powers of two run into saturation and stay there
    apply_setting(16'd1, 16'd2, 16'd65535, 16'd2, 16'd2, 16'd2, 16'd2);
    send_request(11'd31);
    send_request(11'd32);
    send_request(11'd33);
    send_request(11'd1025);
    finish_burst();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady = ($urandom_range(0, 3) == 0);
      foreach (pick[k]) pick[k] = random_prime();
      apply_setting(random_count_word(), pick[0], pick[1], pick[2], pick[3], pick[4], pick[5]);
      repeat (PHASE_REQUESTS) send_request(random_position());
      finish_burst();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
